// ----- hw/rtl/ihl_pkg.sv -----
// Shared types, codes and helpers for the Intel HEX record loader.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`default_nettype none

package ihl_pkg;

    // Input item: one text character or an end-of-input marker
    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
    } ihl_in_t;

    // Result item: memory byte write or final load report
    typedef struct packed {
        logic        kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        load_ok;
        logic [1:0]  error_code;
        logic [23:0] loaded_bytes;
    } ihl_out_t;

    // Parser result toward the output register
    typedef struct packed {
        logic     valid;
        ihl_out_t item;
    } ihl_result_t;

    // Line parse phase
    typedef enum logic [1:0] {
        PHASE_START  = 2'd0,
        PHASE_RECORD = 2'd1,
        PHASE_SKIP   = 2'd2
    } ihl_phase_t;

    localparam logic FUNC_CHAR   = 1'b0;
    localparam logic FUNC_END    = 1'b1;
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_HEADER   = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] BAD_BYTE   = 8'hFF;

    localparam int unsigned POS_W      = 10;
    localparam logic [POS_W-1:0] POS_MAX     = 10'd1023;
    localparam logic [POS_W-1:0] HEADER_LEN  = 10'd9;
    localparam logic [POS_W-1:0] HEADER_LAST = 10'd8;

    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    // Pending nibble flag: first digit of a pair was not hex
    localparam logic [4:0] NIBBLE_BAD = 5'h10;

    // bit 4 set: not a hex digit; bits 3:0: digit value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = NIBBLE_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            res = {1'b0, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ihl_in_reg.sv -----
// Input register of the HEX loader: holds one accepted item for the parser.
// Depends on ihl_pkg (ihl_in_t).
`default_nettype none

module ihl_in_reg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ihl_pkg::ihl_in_t s_data,
    input  wire logic            step,
    output logic                 item_valid,
    output ihl_pkg::ihl_in_t     item
);

    logic             valid_reg;
    logic             valid_next;
    ihl_pkg::ihl_in_t data_reg;

    // Free slot, or the held item leaves this cycle
    assign s_ready = !valid_reg || step;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ihl_parser.sv -----
// Record parser of the HEX loader: line state, checksum, totals, result build.
// Depends on ihl_pkg (types, codes, hex_digit).
`default_nettype none

module ihl_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [16:0]      memory_size,
    input  wire logic             step,
    input  wire ihl_pkg::ihl_in_t item,
    output ihl_pkg::ihl_result_t  result
);

    ihl_pkg::ihl_phase_t phase_reg, phase_next;
    logic [9:0]  pos_reg, pos_next;
    logic [4:0]  pend_reg, pend_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  csum_reg, csum_next;
    logic        fits_reg, fits_next;
    logic [23:0] total_reg, total_next;
    logic [1:0]  err_reg, err_next;

    // Character decode
    logic [4:0] hd;
    logic       is_hex;
    logic [3:0] dig;
    logic [9:0] r;
    logic [8:0] j;
    logic       is_char;
    logic       is_lf;
    logic       is_cr;
    logic       header_bad;

    assign hd      = ihl_pkg::hex_digit(item.char_code);
    assign is_hex  = !hd[4];
    assign dig     = hd[3:0];
    assign r       = pos_reg - ihl_pkg::HEADER_LEN;
    assign j       = r[9:1];
    assign is_char = step && (item.func == ihl_pkg::FUNC_CHAR) && (err_reg == ihl_pkg::ERR_NONE);
    assign is_lf   = item.char_code == ihl_pkg::CHAR_LF;
    assign is_cr   = item.char_code == ihl_pkg::CHAR_CR;
    assign header_bad = (phase_reg == ihl_pkg::PHASE_RECORD) && (pos_reg != '0)
                        && (pos_reg <= ihl_pkg::HEADER_LAST) && !is_hex;

    // End-of-line evaluation on current state
    logic [9:0]  j0;
    logic [7:0]  tail_pend;
    logic [7:0]  tail_miss;
    logic [7:0]  csum_fin;
    logic [24:0] total_sum;
    logic [23:0] total_sat;
    logic        line_live;
    logic [1:0]  el_err;
    logic [23:0] el_total;

    assign j0        = {1'b0, r[9:1]} + {9'b0, r[0]};
    assign tail_pend = (r[0] && ({1'b0, j} <= {2'b0, count_reg}))
                       ? (pend_reg[4] ? ihl_pkg::BAD_BYTE : {4'b0, pend_reg[3:0]}) : 8'h00;
    // missing pairs add (count+1-j0) * 0xFF, i.e. subtract that count
    assign tail_miss = (j0 <= {2'b0, count_reg}) ? (j0[7:0] - count_reg - 8'd1) : 8'h00;
    assign csum_fin  = csum_reg + tail_pend + tail_miss;
    assign total_sum = {1'b0, total_reg} + {17'b0, count_reg};
    assign total_sat = total_sum[24] ? ihl_pkg::TOTAL_MAX : total_sum[23:0];
    assign line_live = (phase_reg == ihl_pkg::PHASE_RECORD) && (err_reg == ihl_pkg::ERR_NONE);

    always_comb begin
        el_err   = err_reg;
        el_total = total_reg;
        if (line_live) begin
            if (pos_reg < ihl_pkg::HEADER_LEN) begin
                el_err = ihl_pkg::ERR_HEADER;
            end else if (csum_fin != 8'h00) begin
                el_err = ihl_pkg::ERR_CHECKSUM;
            end else if (type_reg == 8'h00 && fits_reg) begin
                el_total = total_sat;
            end
        end
    end

    // Line phase next state
    always_comb begin
        phase_next = phase_reg;
        if (step && item.func == ihl_pkg::FUNC_END) begin
            phase_next = ihl_pkg::PHASE_START;
        end else if (is_char && !is_cr) begin
            if (is_lf) begin
                phase_next = ihl_pkg::PHASE_START;
            end else if (pos_reg == '0) begin
                phase_next = (item.char_code == ihl_pkg::CHAR_COLON)
                             ? ihl_pkg::PHASE_RECORD : ihl_pkg::PHASE_SKIP;
            end else if (header_bad) begin
                phase_next = ihl_pkg::PHASE_SKIP;
            end
        end
    end

    // Datapath next state and result
    always_comb begin
        logic       good;
        logic [7:0] v;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        type_next  = type_reg;
        csum_next  = csum_reg;
        fits_next  = fits_reg;
        total_next = total_reg;
        err_next   = err_reg;
        result     = '0;
        good       = 1'b0;
        v          = ihl_pkg::BAD_BYTE;

        if (step && item.func == ihl_pkg::FUNC_END) begin
            result.valid             = 1'b1;
            result.item.kind         = ihl_pkg::KIND_REPORT;
            result.item.load_ok      = (el_err == ihl_pkg::ERR_NONE);
            result.item.error_code   = el_err;
            result.item.loaded_bytes = (el_err == ihl_pkg::ERR_NONE) ? el_total : '0;
            pos_next   = '0;
            pend_next  = '0;
            count_next = '0;
            addr_next  = '0;
            type_next  = '0;
            csum_next  = '0;
            fits_next  = 1'b0;
            total_next = '0;
            err_next   = ihl_pkg::ERR_NONE;
        end else if (is_char && !is_cr) begin
            if (is_lf) begin
                err_next   = el_err;
                total_next = el_total;
                pos_next   = '0;
                pend_next  = '0;
                count_next = '0;
                addr_next  = '0;
                type_next  = '0;
                csum_next  = '0;
                fits_next  = 1'b0;
            end else begin
                if (pos_reg < ihl_pkg::POS_MAX) begin
                    pos_next = pos_reg + 10'd1;
                end
                if (pos_reg != '0 && phase_reg == ihl_pkg::PHASE_RECORD) begin
                    if (pos_reg <= ihl_pkg::HEADER_LAST) begin
                        if (!is_hex) begin
                            err_next = ihl_pkg::ERR_HEADER;
                        end else begin
                            case (pos_reg) inside
                                [10'd1:10'd2]: begin
                                    count_next = {count_reg[3:0], dig};
                                    if (pos_reg == 10'd2) begin
                                        csum_next = csum_reg + count_next;
                                    end
                                end
                                [10'd3:10'd6]: begin
                                    addr_next = {addr_reg[11:0], dig};
                                    if (pos_reg == 10'd4 || pos_reg == 10'd6) begin
                                        csum_next = csum_reg + addr_next[7:0];
                                    end
                                end
                                default: begin
                                    type_next = {type_reg[3:0], dig};
                                    if (pos_reg == ihl_pkg::HEADER_LAST) begin
                                        csum_next = csum_reg + type_next;
                                        fits_next = ({1'b0, addr_reg} + {9'b0, count_reg})
                                                    <= memory_size;
                                    end
                                end
                            endcase
                        end
                    end else if (j <= {1'b0, count_reg}) begin
                        if (!r[0]) begin
                            pend_next = is_hex ? {1'b0, dig} : ihl_pkg::NIBBLE_BAD;
                        end else begin
                            good      = !pend_reg[4] && is_hex;
                            v         = good ? {pend_reg[3:0], dig} : ihl_pkg::BAD_BYTE;
                            csum_next = csum_reg + v;
                            if (good && (j < {1'b0, count_reg}) && type_reg == 8'h00
                                && fits_reg) begin
                                result.valid              = 1'b1;
                                result.item.kind          = ihl_pkg::KIND_WRITE;
                                result.item.write_address = addr_reg + {7'b0, j};
                                result.item.write_data    = v;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ihl_pkg::PHASE_START;
            pos_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
            addr_reg  <= '0;
            type_reg  <= '0;
            csum_reg  <= '0;
            fits_reg  <= 1'b0;
            total_reg <= '0;
            err_reg   <= ihl_pkg::ERR_NONE;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            type_reg  <= type_next;
            csum_reg  <= csum_next;
            fits_reg  <= fits_next;
            total_reg <= total_next;
            err_reg   <= err_next;
        end
    end

    // No write goes out once an error has latched
    a_no_write_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && result.item.kind == ihl_pkg::KIND_WRITE) |-> err_reg == ihl_pkg::ERR_NONE)
        else $error("write emitted with sticky error set");

    // Error code 3 is never produced
    a_err_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != 2'd3)
        else $error("sticky error holds unused code");

    // Error stays until end of input
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ihl_pkg::ERR_NONE && !(step && item.func == ihl_pkg::FUNC_END))
        |=> $stable(err_reg))
        else $error("sticky error changed before end of input");

    // End of input returns the parse state to reset
    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.func == ihl_pkg::FUNC_END)
        |=> (pos_reg == '0 && total_reg == '0 && err_reg == ihl_pkg::ERR_NONE))
        else $error("state not cleared after report");

endmodule

`default_nettype wire

// ----- hw/rtl/ihl_out_reg.sv -----
// Result register of the HEX loader: holds one result until the sink takes it.
// Depends on ihl_pkg (ihl_out_t, ihl_result_t).
`default_nettype none

module ihl_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ihl_pkg::ihl_result_t result,
    input  wire logic                 step,
    output logic                      slot_free,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ihl_pkg::ihl_out_t         m_data
);

    logic              valid_reg;
    logic              valid_next;
    ihl_pkg::ihl_out_t data_reg;
    logic              load;

    assign slot_free = !valid_reg || m_ready;
    assign load      = step && result.valid;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result.item;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/intel_hex_record_loader.sv -----
// Top level of the Intel HEX record loader: input register, parser, result register.
// Depends on ihl_pkg, ihl_in_reg, ihl_parser and ihl_out_reg.
//
// Feed the HEX text one character per transfer (func = 0), then one end-of-input
// transfer (func = 1). Each completed data byte of a type 0 record that fits below
// memory_size comes out as a write result in character order; end of input gives one
// report (load_ok, error_code, loaded_bytes) and returns the parser to its reset state
// for the next file. CR is dropped, LF ends a line, lines without a leading colon are
// skipped. The first error is sticky until end of input. Throughput is one character
// per clock: all per-character work is a single pass of narrow logic between the input
// register and the result register, so a transfer is taken every cycle unless both
// registers hold an item and m_ready is low. An accepted character passes through the input
// register and then the result register on its way to its write result. memory_size is written
// through cfg_wr_en/cfg_wr_data; write it only while no characters are in flight.
`default_nettype none

module intel_hex_record_loader (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [16:0]       cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ihl_pkg::ihl_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ihl_pkg::ihl_out_t      m_data
);

    // Target memory size, reset to the full 64 KiB
    logic [16:0] memory_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_size_reg <= 17'h10000;
        end else if (cfg_wr_en) begin
            memory_size_reg <= cfg_wr_data;
        end
    end

    logic                 item_valid;
    ihl_pkg::ihl_in_t     item;
    logic                 slot_free;
    logic                 step;
    ihl_pkg::ihl_result_t result;

    // Parser advances on a held character whenever the result register can take
    // its output; characters with no result advance on the same condition.
    assign step = item_valid && slot_free;

    ihl_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    ihl_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .memory_size (memory_size_reg),
        .step        (step),
        .item        (item),
        .result      (result)
    );

    ihl_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .result    (result),
        .step      (step),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
